### hdl/sspw_pkg.sv
// ----------------------------------------------------------------------------
// sspw_pkg
// Shared constants and types for the spread-spectrum pixel watermark block.
// ----------------------------------------------------------------------------
package sspw_pkg;

  localparam int PixW   = 16;
  localparam int SeedW  = 32;
  localparam int CfgW   = 32;
  localparam int CfgIdxW = 2;

  // LCG step: state * LcgMul + LcgAdd, modulo 2^32
  localparam logic [SeedW-1:0] LcgMul = 32'd1664525;
  localparam logic [SeedW-1:0] LcgAdd = 32'd1013904223;

  localparam int MarkBit  = 15;  // mark pixel bit that carries the watermark
  localparam int ChipBit  = 16;  // LCG state bit mixed into the chip
  localparam int RefBit   = 12;  // reference pixel bit kept for the next item

  localparam logic [PixW-1:0] PixMax    = 16'hFFFF;
  localparam logic [PixW-1:0] StepReset = 16'd256;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegEmbedMode = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSeed      = 2'd1;
  localparam logic [CfgIdxW-1:0] RegStepSize  = 2'd2;

  // datapath results handed back to the top level
  typedef struct packed {
    logic [PixW-1:0] out_pixel;
    logic            chip;
    logic            ref_bit;
  } sspw_result_t;

endpackage

### hdl/sspw_if.sv
// ----------------------------------------------------------------------------
// sspw_in_if / sspw_out_if
// Valid/ready channels for source pixels and watermarked pixels.
// ----------------------------------------------------------------------------
interface sspw_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel;
  logic [15:0] mark_pixel;
  logic        first;

  modport source (output valid, output pixel, output mark_pixel, output first,
                  input ready);
  modport sink   (input valid, input pixel, input mark_pixel, input first,
                  output ready);
endinterface

interface sspw_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_pixel;
  logic        chip;

  modport source (output valid, output out_pixel, output chip, input ready);
  modport sink   (input valid, input out_pixel, input chip, output ready);
endinterface

### hdl/sspw_lcg.sv
// ----------------------------------------------------------------------------
// sspw_lcg
// One step of the linear congruential generator, with reload from the seed.
// ----------------------------------------------------------------------------
module sspw_lcg
  import sspw_pkg::*;
(
  input  logic [SeedW-1:0] state,
  input  logic [SeedW-1:0] seed,
  input  logic             reload,
  output logic [SeedW-1:0] state_next
);

  logic [SeedW-1:0] base;

  assign base       = reload ? seed : state;
  // 32x21 constant multiply, truncated to 32 bits
  assign state_next = base * LcgMul + LcgAdd;

endmodule

### hdl/sspw_mark.sv
// ----------------------------------------------------------------------------
// sspw_mark
// Chip forming, add or subtract of the step size, clamp and reference bit.
// ----------------------------------------------------------------------------
module sspw_mark
  import sspw_pkg::*;
(
  input  logic [PixW-1:0] pixel,
  input  logic            mark_bit,
  input  logic            lcg_bit,
  input  logic            prev_bit,
  input  logic            embed_mode,
  input  logic [PixW-1:0] step_size,
  output sspw_result_t    result
);

  logic              chip;
  logic              do_add;
  logic [PixW+1:0]   sum;     // signed, one guard bit for the sign
  logic              neg;
  logic              over;

  assign chip   = mark_bit ^ lcg_bit ^ prev_bit;
  // embed: +step on chip 1; remove: -step on chip 1
  assign do_add = (chip == embed_mode);
  assign sum    = do_add ? ({2'b00, pixel} + {2'b00, step_size})
                         : ({2'b00, pixel} - {2'b00, step_size});
  assign neg    = sum[PixW+1];
  assign over   = !neg && sum[PixW];

  always_comb begin
    result.chip = chip;
    if (neg) begin
      result.out_pixel = '0;
    end else if (over) begin
      result.out_pixel = PixMax;
    end else begin
      result.out_pixel = sum[PixW-1:0];
    end
    // remove mode keeps the unclamped result, two's complement when negative
    result.ref_bit = embed_mode ? pixel[RefBit] : sum[RefBit];
  end

endmodule

### hdl/spread_spectrum_pixel_watermark_core.sv
// ----------------------------------------------------------------------------
// spread_spectrum_pixel_watermark_core
// Embeds or removes an LCG spread-spectrum watermark, one pixel per item.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake     payload
//  -------  ---  ------------  -------------------------------------------
//  pix_in   in   valid/ready   pixel[15:0], mark_pixel[15:0], first
//  pix_out  out  valid/ready   out_pixel[15:0], chip
//  cfg      in   cfg_we        cfg_index[1:0], cfg_wdata[31:0]
//
//  One item per cycle while pix_out does not stall; a result shows in the
//  cycle after its item is taken. The loop that sets this rate is the LCG
//  multiply and the previous-bit feedback, both closed in the accept cycle.
//  Reset (rst, synchronous) empties the output register, restores the
//  registers to embed on, seed 0, step 256, and clears generator state.
//  pix_in.ready stays high while the output register is empty or draining,
//  so a stall on pix_out holds back exactly one item.
//
module spread_spectrum_pixel_watermark_core
  import sspw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_wdata,
  sspw_in_if.sink            pix_in,
  sspw_out_if.source         pix_out
);

  // configuration registers
  logic             embed_mode;
  logic [SeedW-1:0] seed;
  logic [PixW-1:0]  step_size;

  // generator state
  logic [SeedW-1:0] lcg_state;
  logic [SeedW-1:0] lcg_state_next;
  logic             prev_bit;
  logic             prev_cur;

  // output register
  logic             out_valid;
  logic [PixW-1:0]  out_pixel;
  logic             out_chip;

  logic             accept;
  sspw_result_t     result;

  always_ff @(posedge clk) begin
    if (rst) begin
      embed_mode <= 1'b1;
      seed       <= '0;
      step_size  <= StepReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegEmbedMode: embed_mode <= cfg_wdata[0];
        RegSeed:      seed       <= cfg_wdata[SeedW-1:0];
        RegStepSize:  step_size  <= cfg_wdata[PixW-1:0];
        default:      ;  // unknown index: ignored
      endcase
    end
  end

  // output register frees up whenever it is empty or being taken
  assign pix_in.ready = !out_valid || pix_out.ready;
  assign accept       = pix_in.valid && pix_in.ready;

  sspw_lcg u_lcg (
    .state      (lcg_state),
    .seed       (seed),
    .reload     (pix_in.first),
    .state_next (lcg_state_next)
  );

  // first item of a frame starts from a cleared previous bit
  assign prev_cur = pix_in.first ? 1'b0 : prev_bit;

  sspw_mark u_mark (
    .pixel      (pix_in.pixel),
    .mark_bit   (pix_in.mark_pixel[MarkBit]),
    .lcg_bit    (lcg_state_next[ChipBit]),
    .prev_bit   (prev_cur),
    .embed_mode (embed_mode),
    .step_size  (step_size),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_state <= '0;
      prev_bit  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        lcg_state <= lcg_state_next;
        prev_bit  <= result.ref_bit;
        out_valid <= 1'b1;
      end else if (pix_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_pixel <= result.out_pixel;
      out_chip  <= result.chip;
    end
  end

  assign pix_out.valid     = out_valid;
  assign pix_out.out_pixel = out_pixel;
  assign pix_out.chip      = out_chip;

endmodule

### hdl/sspw_checker.sv
// ----------------------------------------------------------------------------
// sspw_checker
// Port-level checks on the watermark core, bound to the top level.
// ----------------------------------------------------------------------------
module sspw_checker
  import sspw_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [PixW-1:0] out_pixel,
  input logic            out_chip
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // every accepted item shows a result in the next cycle
  a_item_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item gave no result");

  // an empty output register never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(out_chip))
    else $error("stalled result changed");

endmodule

bind spread_spectrum_pixel_watermark_core sspw_checker u_sspw_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pix_in.valid),
  .in_ready  (pix_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .out_pixel (pix_out.out_pixel),
  .out_chip  (pix_out.chip)
);
